### src/pts_pkg.sv
// Shared types, widths and helpers for the perceptron training step block.
// No dependencies; used by pts_lane, pts_merge and perceptron_train_step_top.
package pts_pkg;

  localparam int NUM_FEATURES_DEF = 4;

  localparam int FEAT_W   = 16;
  localparam int WEIGHT_W = 32;
  localparam int RATE_W   = 3;
  localparam int ERR_W    = 48;
  localparam int CFG_W    = 32;

  // weight * feature, exact Q20.28
  localparam int PROD_W   = WEIGHT_W + FEAT_W;
  // |target - sum| fits in 32 unsigned bits
  localparam int DMAG_W   = 32;
  // rate * |diff|
  localparam int NT_W     = DMAG_W + RATE_W;
  // rate * |diff| * |feature|
  localparam int UPD_W    = NT_W + FEAT_W;
  localparam int FRAC_SH  = 12;
  localparam int DIV_IN_W = UPD_W - FRAC_SH;

  // divide by ten, one byte digit per step
  localparam int DIGIT_W    = 8;
  localparam int DIV_DIGITS = (DIV_IN_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W      = DIV_DIGITS * DIGIT_W;
  localparam int REM_W      = 4;
  localparam int DX_W       = REM_W + DIGIT_W;
  localparam int RECIP_10   = 3277;
  localparam int RECIP_SH   = 15;
  localparam int RMUL_W     = 24;

  localparam logic signed [WEIGHT_W-1:0] INIT_WEIGHT_RST = 32'sd65536;
  localparam logic [RATE_W-1:0]          RATE_RST        = 3'd1;
  localparam logic signed [32:0]         ONE_Q16         = 33'sd65536;
  localparam logic [ERR_W-1:0]           ERR_MAX         = {ERR_W{1'b1}};

  // register indexes
  localparam int CFG_LEARNING_RATE = 0;
  localparam int CFG_INIT_WEIGHT   = 1;

  // per-step controls from the sequencer to every lane
  typedef struct packed {
    logic load;      // latch feature word
    logic restart;   // reload weight from initial value
    logic dot;       // form weight * feature
    logic scale;     // form update magnitude and load divider
    logic div_step;  // one divide-by-ten digit
    logic commit;    // write updated weight
  } lane_ctl_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[WEIGHT_W-1:0];
    end
  endfunction

endpackage

### src/pts_lane.sv
// One feature lane: holds its weight, forms the dot-product term and the
// weight update with a byte-serial divide by ten. Depends on pts_pkg.
module pts_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pts_pkg::lane_ctl_t                   ctl,
  input  logic signed [pts_pkg::FEAT_W-1:0]    feature,
  input  logic signed [pts_pkg::WEIGHT_W-1:0]  init_w,
  input  logic [pts_pkg::NT_W-1:0]             nt_mag,
  input  logic                                 nt_neg,
  output logic signed [pts_pkg::PROD_W-1:0]    prod
);

  localparam int FW = pts_pkg::FEAT_W;
  localparam int WW = pts_pkg::WEIGHT_W;
  localparam int DW = pts_pkg::DIV_W;
  localparam int GW = pts_pkg::DIGIT_W;
  localparam int RW = pts_pkg::REM_W;
  localparam int XW = pts_pkg::DX_W;
  localparam int MW = pts_pkg::RMUL_W;
  localparam int UW = pts_pkg::UPD_W;
  localparam int SW = DW + 2;

  logic signed [WW-1:0]                weight_r;
  logic signed [FW-1:0]                feature_r;
  logic signed [pts_pkg::PROD_W-1:0]   prod_r;
  logic [DW-1:0]                       div_r;
  logic [RW-1:0]                       rem_r;
  logic                                sign_r;

  logic [FW-1:0]  f_mag;
  logic [UW-1:0]  upd_mag;
  logic [XW-1:0]  dx;
  logic [MW-1:0]  rmul;
  logic [GW-1:0]  qd;
  logic [XW-1:0]  qd10;
  logic [RW-1:0]  rem_nxt;
  logic signed [SW-1:0] delta;
  logic signed [SW-1:0] wsum;

  // magnitude of the feature; -32768 maps to 32768
  assign f_mag   = feature_r[FW-1] ? (~feature_r + 1'b1) : feature_r;
  assign upd_mag = UW'(nt_mag) * UW'(f_mag);

  // one digit of long division by ten
  assign dx      = {rem_r, div_r[DW-1 -: GW]};
  assign rmul    = MW'(dx) * MW'(pts_pkg::RECIP_10);
  assign qd      = rmul[pts_pkg::RECIP_SH +: GW];
  assign qd10    = (XW'(qd) << 3) + (XW'(qd) << 1);
  assign rem_nxt = RW'(dx - qd10);

  // signed quotient added to the weight
  assign delta = sign_r ? -$signed({2'b00, div_r}) : $signed({2'b00, div_r});
  assign wsum  = SW'(weight_r) + delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= pts_pkg::INIT_WEIGHT_RST;
    end else begin
      if (ctl.load && ctl.restart) begin
        weight_r <= init_w;
      end else if (ctl.commit) begin
        weight_r <= pts_pkg::sat32(64'(wsum));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      feature_r <= feature;
    end
    if (ctl.dot) begin
      prod_r <= pts_pkg::PROD_W'(weight_r) * pts_pkg::PROD_W'(feature_r);
    end
    if (ctl.scale) begin
      div_r  <= DW'(upd_mag >> pts_pkg::FRAC_SH);
      rem_r  <= '0;
      sign_r <= nt_neg ^ feature_r[FW-1];
    end else if (ctl.div_step) begin
      div_r <= {div_r[DW-GW-1:0], qd};
      rem_r <= rem_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### src/pts_merge.sv
// Merge stage: adds the lane terms, divides by 4096 toward zero and
// saturates to the Q16.16 weighted sum. Depends on pts_pkg.
module pts_merge #(
  parameter int NUM_FEATURES = pts_pkg::NUM_FEATURES_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [pts_pkg::PROD_W-1:0]    prod [NUM_FEATURES],
  output logic signed [pts_pkg::WEIGHT_W-1:0]  sum
);

  localparam int SUM_W = pts_pkg::PROD_W + $clog2(NUM_FEATURES);

  logic signed [SUM_W-1:0]             acc;
  logic signed [SUM_W-1:0]             adj;
  logic signed [SUM_W-1:0]             quo;
  logic signed [pts_pkg::WEIGHT_W-1:0] sum_r;

  // adder chain over the lanes
  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_FEATURES; k++) begin
      acc = acc + SUM_W'(prod[k]);
    end
  end

  // truncating divide by 4096: bias negatives before the shift
  assign adj = acc + (acc[SUM_W-1] ? SUM_W'(4095) : SUM_W'(0));
  assign quo = adj >>> pts_pkg::FRAC_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= pts_pkg::sat32(64'(quo));
    end
  end

  assign sum = sum_r;

endmodule

### src/perceptron_train_step_top.sv
// Perceptron training step: one sample word in, one result word out.
// From accept: ST_DOT, ST_MERGE, ST_DIFF, then ST_FIN without a mismatch, or via
// ST_SCALE, ST_DIVIDE, ST_UPDATE with one; next word accepted once back in ST_IDLE.
// The per-lane byte-serial divide by ten (DIV_DIGITS steps) sets the update time.
// Reset: rate 1, initial and current weights 1.0, epoch error 0, no word held.
// Depends on pts_pkg, pts_lane, pts_merge.
module perceptron_train_step_top #(
  parameter int NUM_FEATURES = pts_pkg::NUM_FEATURES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pts_pkg::FEAT_W-1:0]    in_feature [NUM_FEATURES],
  input  logic                                 in_target_positive,
  input  logic                                 in_epoch_start,
  input  logic                                 in_restart,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pts_pkg::WEIGHT_W-1:0]  out_weighted_sum,
  output logic                                 out_predicted_positive,
  output logic                                 out_mismatch,
  output logic [pts_pkg::ERR_W-1:0]            out_epoch_error,
  // configuration
  input  logic                                 cfg_we,
  input  logic [$clog2(NUM_FEATURES+1)-1:0]    cfg_index,
  input  logic [pts_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_FEATURES + 1);
  localparam int CNT_W = $clog2(pts_pkg::DIV_DIGITS);
  localparam int WW    = pts_pkg::WEIGHT_W;
  localparam int EW    = pts_pkg::ERR_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DOT, ST_MERGE, ST_DIFF, ST_SCALE, ST_DIVIDE, ST_UPDATE, ST_FIN
  } state_t;

  state_t                       state_r;
  logic [pts_pkg::RATE_W-1:0]   rate_r;
  logic signed [WW-1:0]         init_w_r [NUM_FEATURES];
  logic [EW-1:0]                err_r;
  logic                         tpos_r;
  logic                         pred_r;
  logic                         miss_r;
  logic [pts_pkg::DMAG_W-1:0]   dmag_r;
  logic [pts_pkg::NT_W-1:0]     nt_mag_r;
  logic                         nt_neg_r;
  logic [63:0]                  sq_r;
  logic [CNT_W-1:0]             div_cnt_r;
  logic                         out_valid_r;
  logic signed [WW-1:0]         out_sum_r;
  logic                         out_pred_r;
  logic                         out_miss_r;
  logic [EW-1:0]                out_err_r;

  pts_pkg::lane_ctl_t           ctl;
  logic signed [pts_pkg::PROD_W-1:0] prod [NUM_FEATURES];
  logic signed [WW-1:0]         sum;
  logic                         accept;
  logic                         out_free;
  logic signed [32:0]           target;
  logic signed [32:0]           diff;
  logic [pts_pkg::DMAG_W-1:0]   dmag;
  logic                         pred;
  logic [63:0]                  err_add;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // lane controls decoded from the sequencer state
  always_comb begin
    ctl          = '0;
    ctl.load     = accept;
    ctl.restart  = in_restart;
    ctl.dot      = (state_r == ST_DOT);
    ctl.scale    = (state_r == ST_SCALE);
    ctl.div_step = (state_r == ST_DIVIDE);
    ctl.commit   = (state_r == ST_UPDATE);
  end

  for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_lane
    pts_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .feature (in_feature[k]),
      .init_w  (init_w_r[k]),
      .nt_mag  (nt_mag_r),
      .nt_neg  (nt_neg_r),
      .prod    (prod[k])
    );
  end

  pts_merge #(.NUM_FEATURES(NUM_FEATURES)) u_merge (
    .clk  (clk),
    .en   (state_r == ST_MERGE),
    .prod (prod),
    .sum  (sum)
  );

  // error term: target - sum, as sign and magnitude
  assign target = tpos_r ? pts_pkg::ONE_Q16 : -pts_pkg::ONE_Q16;
  assign diff   = target - 33'(sum);
  assign dmag   = pts_pkg::DMAG_W'(diff[32] ? -diff : diff);
  assign pred   = (sum > 0);
  assign err_add = 64'(err_r) + (sq_r >> 1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= pts_pkg::RATE_RST;
      for (int k = 0; k < NUM_FEATURES; k++) begin
        init_w_r[k] <= pts_pkg::INIT_WEIGHT_RST;
      end
    end else if (cfg_we) begin
      if (cfg_index == IDX_W'(pts_pkg::CFG_LEARNING_RATE)) begin
        rate_r <= cfg_wdata[pts_pkg::RATE_W-1:0];
      end
      for (int k = 0; k < NUM_FEATURES; k++) begin
        if (cfg_index == IDX_W'(pts_pkg::CFG_INIT_WEIGHT + k)) begin
          init_w_r[k] <= cfg_wdata[WW-1:0];
        end
      end
    end
  end

  // sequencer, epoch error and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            tpos_r <= in_target_positive;
            if (in_epoch_start) begin
              err_r <= '0;
            end
            state_r <= ST_DOT;
          end
        end
        ST_DOT: begin
          state_r <= ST_MERGE;
        end
        ST_MERGE: begin
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          pred_r   <= pred;
          miss_r   <= (pred != tpos_r);
          dmag_r   <= dmag;
          nt_mag_r <= pts_pkg::NT_W'(rate_r) * pts_pkg::NT_W'(dmag);
          nt_neg_r <= diff[32];
          state_r  <= (pred != tpos_r) ? ST_SCALE : ST_FIN;
        end
        ST_SCALE: begin
          sq_r      <= 64'(dmag_r) * 64'(dmag_r);
          div_cnt_r <= '0;
          state_r   <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == CNT_W'(pts_pkg::DIV_DIGITS - 1)) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // saturating half squared error
          if (err_add > 64'(pts_pkg::ERR_MAX)) begin
            err_r <= pts_pkg::ERR_MAX;
          end else begin
            err_r <= err_add[EW-1:0];
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= sum;
            out_pred_r  <= pred_r;
            out_miss_r  <= miss_r;
            out_err_r   <= err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_weighted_sum       = out_sum_r;
  assign out_predicted_positive = out_pred_r;
  assign out_mismatch           = out_miss_r;
  assign out_epoch_error        = out_err_r;

  // weight updates are committed only for a misclassified sample
  a_commit_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> miss_r)
    else $error("weight update without mismatch");

  // epoch start clears the running error
  a_epoch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_epoch_start |=> err_r == '0)
    else $error("epoch error not cleared");

  // divider step count stays within its digit count
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE |-> div_cnt_r <= CNT_W'(pts_pkg::DIV_DIGITS - 1))
    else $error("divider step count overrun");

  // reported prediction matches the reported sum
  a_pred_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pred_r == (out_sum_r > 0))
    else $error("prediction disagrees with weighted sum");

endmodule

### dv/testbench.sv
// Self-checking testbench for perceptron_train_step_top: a directed table, then
// random sample words across several register settings, checked by a predictor.
// Depends on pts_pkg and the perceptron_train_step_top RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_FEAT       = pts_pkg::NUM_FEATURES_DEF;
  localparam int IDX_W          = $clog2(NUM_FEAT + 1);
  localparam int IDX_SPARE_LO   = pts_pkg::CFG_INIT_WEIGHT + NUM_FEAT;
  localparam int IDX_TOP        = (1 << IDX_W) - 1;
  localparam int SCRIPT_LEN     = 35;
  localparam int PHASES         = 6;
  localparam int QUIET_PHASE    = 3;
  localparam int RAND_PER_PHASE = 250;
  localparam int SETTLE_CYCLES  = 24;
  localparam longint unsigned ERR_FULL = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [NUM_FEAT-1:0][pts_pkg::FEAT_W-1:0] feat;
    logic                                     tpos;
    logic                                     epoch;
    logic                                     restart;
  } sample_t;

  typedef struct packed {
    logic [pts_pkg::WEIGHT_W-1:0] sum;
    logic                         pred;
    logic                         miss;
    logic [pts_pkg::ERR_W-1:0]    err;
  } outcome_t;

  typedef struct packed {
    logic                      is_cfg;
    logic [IDX_W-1:0]          idx;
    logic [pts_pkg::CFG_W-1:0] data;
    sample_t                   smp;
    logic                      has_known;
    outcome_t                  known;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [pts_pkg::FEAT_W-1:0] in_feature [NUM_FEAT];
  logic in_target_positive;
  logic in_epoch_start;
  logic in_restart;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [pts_pkg::WEIGHT_W-1:0] out_weighted_sum;
  logic out_predicted_positive;
  logic out_mismatch;
  logic [pts_pkg::ERR_W-1:0] out_epoch_error;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [pts_pkg::CFG_W-1:0] cfg_wdata;

  // predictor state: registers, live weights, epoch error
  logic [pts_pkg::RATE_W-1:0] p_rate;
  longint            p_init_w [NUM_FEAT];
  longint            p_weight [NUM_FEAT];
  longint unsigned   p_err_sum;

  outcome_t outcome_q [$];
  row_t     script [SCRIPT_LEN];
  int       fail_count = 0;
  bit       jitter_on = 1'b1;
  int       ready_hold = 0;

  int                        corner_f [5] = '{32767, -32768, 0, -1, 1};
  logic [pts_pkg::CFG_W-1:0] corner_w [3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};

  perceptron_train_step_top #(
    .NUM_FEATURES(NUM_FEAT)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_feature             (in_feature),
    .in_target_positive     (in_target_positive),
    .in_epoch_start         (in_epoch_start),
    .in_restart             (in_restart),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_weighted_sum       (out_weighted_sum),
    .out_predicted_positive (out_predicted_positive),
    .out_mismatch           (out_mismatch),
    .out_epoch_error        (out_epoch_error),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** perceptron_train_step_top: FAILED **");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // one training step: classify, then learn on a miss
  function automatic outcome_t learn_step(input sample_t s);
    outcome_t        r;
    longint          acc;
    longint          sum;
    longint          diff;
    longint          nt;
    longint          f;
    longint unsigned mag;
    longint unsigned half;
    logic            pred;
    if (s.epoch) begin
      p_err_sum = 0;
    end
    if (s.restart) begin
      for (int k = 0; k < NUM_FEAT; k++) p_weight[k] = p_init_w[k];
    end
    acc = 0;
    for (int k = 0; k < NUM_FEAT; k++) begin
      f = longint'($signed(s.feat[k]));
      acc += p_weight[k] * f;
    end
    sum = clamp32(acc / 4096);
    pred = (sum > 0);
    r.sum = sum[pts_pkg::WEIGHT_W-1:0];
    r.pred = pred;
    r.miss = (pred != s.tpos);
    if (r.miss) begin
      diff = (s.tpos ? 64'sd65536 : -64'sd65536) - sum;
      nt = longint'({61'd0, p_rate}) * diff;
      for (int k = 0; k < NUM_FEAT; k++) begin
        f = longint'($signed(s.feat[k]));
        p_weight[k] = clamp32(p_weight[k] + (nt * f) / 40960);
      end
      mag = (diff < 0) ? longint'(-diff) : longint'(diff);
      half = (mag * mag) >> 1;
      if (half > ERR_FULL - p_err_sum) begin
        p_err_sum = ERR_FULL;
      end else begin
        p_err_sum += half;
      end
    end
    r.err = p_err_sum[pts_pkg::ERR_W-1:0];
    return r;
  endfunction

  // table row builders
  function automatic row_t row_sample(input int f0, input int f1, input int f2, input int f3,
                                      input bit t, input bit e, input bit rs);
    row_t r;
    r = '0;
    r.smp.feat[0] = pts_pkg::FEAT_W'(f0);
    r.smp.feat[1] = pts_pkg::FEAT_W'(f1);
    r.smp.feat[2] = pts_pkg::FEAT_W'(f2);
    r.smp.feat[3] = pts_pkg::FEAT_W'(f3);
    r.smp.tpos = t;
    r.smp.epoch = e;
    r.smp.restart = rs;
    return r;
  endfunction

  function automatic row_t row_known(input int f0, input int f1, input int f2, input int f3,
                                     input bit t, input bit e, input bit rs,
                                     input logic [pts_pkg::WEIGHT_W-1:0] sum, input bit pred,
                                     input bit miss, input logic [pts_pkg::ERR_W-1:0] err);
    row_t r;
    r = row_sample(f0, f1, f2, f3, t, e, rs);
    r.has_known = 1'b1;
    r.known.sum = sum;
    r.known.pred = pred;
    r.known.miss = miss;
    r.known.err = err;
    return r;
  endfunction

  function automatic row_t row_reg(input int idx, input logic [pts_pkg::CFG_W-1:0] data);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = IDX_W'(idx);
    r.data = data;
    return r;
  endfunction

  // random hold-off before a sample word, mostly none
  task automatic in_gap();
    int roll;
    int len;
    roll = $urandom_range(0, 99);
    if (!jitter_on || roll < 60) begin
      len = 0;
    end else if (roll < 94) begin
      len = $urandom_range(1, 3);
    end else begin
      len = $urandom_range(10, 40);
    end
    if (len != 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // present one sample word, hold until taken, queue its outcome
  task automatic send_sample(input sample_t s, input bit use_known, input outcome_t known);
    outcome_t calc;
    in_valid <= 1'b1;
    for (int k = 0; k < NUM_FEAT; k++) in_feature[k] <= s.feat[k];
    in_target_positive <= s.tpos;
    in_epoch_start <= s.epoch;
    in_restart <= s.restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = learn_step(s);
    outcome_q.push_back(use_known ? known : calc);
  endtask

  // drop valid, let every outcome drain, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; caller drops cfg_we after the last one of a batch
  task automatic write_reg(input int idx, input logic [pts_pkg::CFG_W-1:0] data);
    logic [IDX_W-1:0] slot;
    slot = IDX_W'(idx);
    cfg_we <= 1'b1;
    cfg_index <= slot;
    cfg_wdata <= data;
    @(posedge clk);
    if (int'(slot) == pts_pkg::CFG_LEARNING_RATE) begin
      p_rate = data[pts_pkg::RATE_W-1:0];
    end else if (int'(slot) >= pts_pkg::CFG_INIT_WEIGHT &&
                 int'(slot) < pts_pkg::CFG_INIT_WEIGHT + NUM_FEAT) begin
      p_init_w[int'(slot) - pts_pkg::CFG_INIT_WEIGHT] = longint'($signed(data));
    end
  endtask

  // result side back-pressure: long ready runs, short stalls, a few long ones
  always @(posedge clk) begin : ready_gen
    int roll;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (!jitter_on || roll < 60) begin
        out_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 15);
      end else if (roll < 94) begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(8, 40);
      end
    end
  end

  // compare every accepted result word with the oldest queued outcome
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result word with none pending, sum %h", $time, out_weighted_sum);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_weighted_sum !== want.sum) begin
          $display("%0t: weighted_sum exp %h got %h", $time, want.sum, out_weighted_sum);
          fail_count++;
        end
        if (out_predicted_positive !== want.pred) begin
          $display("%0t: predicted_positive exp %b got %b", $time, want.pred,
                   out_predicted_positive);
          fail_count++;
        end
        if (out_mismatch !== want.miss) begin
          $display("%0t: mismatch exp %b got %b", $time, want.miss, out_mismatch);
          fail_count++;
        end
        if (out_epoch_error !== want.err) begin
          $display("%0t: epoch_error exp %h got %h", $time, want.err, out_epoch_error);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t                       row;
    sample_t                    s;
    logic [pts_pkg::CFG_W-1:0]  wd;
    logic [pts_pkg::RATE_W-1:0] rate;
    int                         val;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    for (int k = 0; k < NUM_FEAT; k++) in_feature[k] <= '0;
    in_target_positive <= 1'b0;
    in_epoch_start <= 1'b0;
    in_restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    p_rate = pts_pkg::RATE_RST;
    for (int k = 0; k < NUM_FEAT; k++) begin
      p_init_w[k] = 65536;
      p_weight[k] = 65536;
    end
    p_err_sum = 0;

    script = '{
      // reset weights 1.0: zero sample, then a miss on zero sum
      row_known(0, 0, 0, 0, 0, 0, 0, 32'h0, 0, 0, 48'h0),
      row_known(0, 0, 0, 0, 1, 0, 0, 32'h0, 0, 1, 48'h0000_8000_0000),
      row_known(4096, 0, 0, 0, 1, 0, 0, 32'h0001_0000, 1, 0, 48'h0000_8000_0000),
      row_known(0, 0, 0, 0, 0, 1, 0, 32'h0, 0, 0, 48'h0),
      // feature extremes, flags alone and together
      row_sample(32767, 32767, 32767, 32767, 0, 0, 0),
      row_sample(-32768, -32768, -32768, -32768, 1, 0, 1),
      row_sample(32767, -32768, 0, 1, 1, 1, 1),
      row_sample(-1, -1, -1, -1, 0, 0, 0),
      row_sample(21845, -21846, 21845, -21846, 1, 0, 0),
      // top rate, weights at max: sum and error both saturate
      row_reg(pts_pkg::CFG_LEARNING_RATE, 32'd7),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 0, 32'h7FFF_FFFF),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 1, 32'h7FFF_FFFF),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 2, 32'h7FFF_FFFF),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 3, 32'h7FFF_FFFF),
      row_known(32767, 32767, 32767, 32767, 0, 1, 1, 32'h7FFF_FFFF, 1, 1, pts_pkg::ERR_MAX),
      row_sample(32767, 32767, 32767, 32767, 0, 0, 0),
      row_sample(-32768, -32768, -32768, -32768, 1, 0, 0),
      // zero rate, weights at min: no weight movement
      row_reg(pts_pkg::CFG_LEARNING_RATE, 32'd0),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 0, 32'h8000_0000),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 1, 32'h8000_0000),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 2, 32'h8000_0000),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 3, 32'h8000_0000),
      row_known(32767, 32767, 32767, 32767, 1, 1, 1, 32'h8000_0000, 0, 1, pts_pkg::ERR_MAX),
      row_known(32767, 32767, 32767, 32767, 1, 0, 0, 32'h8000_0000, 0, 1, pts_pkg::ERR_MAX),
      row_known(0, 0, 0, 0, 0, 1, 0, 32'h0, 0, 0, 48'h0),
      // unused indexes are dropped; rate write with junk upper bits
      row_reg(IDX_SPARE_LO, 32'h1234_5678),
      row_reg(IDX_TOP, 32'hFFFF_FFFF),
      row_reg(pts_pkg::CFG_LEARNING_RATE, 32'hFFFF_FFFB),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 0, 32'h0000_8000),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 1, 32'hFFFF_0000),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 2, 32'h0002_0000),
      row_reg(pts_pkg::CFG_INIT_WEIGHT + 3, 32'h0000_0000),
      row_sample(4096, 4096, 4096, 4096, 1, 0, 1),
      row_sample(-4096, 2048, 8192, -1, 0, 0, 0),
      row_sample(1, -1, 12288, -12288, 1, 0, 0)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        if (in_valid) begin
          settle();
        end
        write_reg(int'(row.idx), row.data);
      end else begin
        cfg_we <= 1'b0;
        in_gap();
        send_sample(row.smp, row.has_known, row.known);
      end
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_we <= 1'b0;
      settle();
      jitter_on = (ph != QUIET_PHASE);
      case (ph)
        0: rate = 3'd7;
        1: rate = 3'd0;
        2: rate = 3'd1;
        default: rate = pts_pkg::RATE_W'($urandom_range(0, 7));
      endcase
      wd = $urandom;
      wd[pts_pkg::RATE_W-1:0] = rate;
      write_reg(pts_pkg::CFG_LEARNING_RATE, wd);
      for (int k = 0; k < NUM_FEAT; k++) begin
        val = $urandom_range(0, 9);
        if (val < 7) begin
          // mostly within +/-4.0 so training stays in range
          wd = $urandom_range(0, 524288) - 262144;
        end else if (val < 9) begin
          wd = $urandom;
        end else begin
          wd = corner_w[$urandom_range(0, 2)];
        end
        write_reg(pts_pkg::CFG_INIT_WEIGHT + k, wd);
      end
      if (IDX_SPARE_LO <= IDX_TOP && $urandom_range(0, 1) == 1) begin
        write_reg($urandom_range(IDX_SPARE_LO, IDX_TOP), $urandom);
      end
      cfg_we <= 1'b0;

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        for (int k = 0; k < NUM_FEAT; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: val = $urandom_range(0, 16384) - 8192;
            5, 6, 7: val = $urandom_range(0, 65535) - 32768;
            8: val = corner_f[$urandom_range(0, 4)];
            default: val = $urandom_range(0, 2048) - 1024;
          endcase
          s.feat[k] = pts_pkg::FEAT_W'(val);
        end
        s.tpos = 1'($urandom_range(0, 1));
        s.epoch = (n == 0) || ($urandom_range(0, 15) == 0);
        s.restart = (n == 0) || ($urandom_range(0, 23) == 0);
        in_gap();
        send_sample(s, 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("** perceptron_train_step_top: PASSED **");
    end else begin
      $display("** perceptron_train_step_top: FAILED **");
    end
    $finish;
  end

endmodule
